>>> design/qxmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_pkg
// Shared types, constants and helpers of the quad X motor mixer.
// ----------------------------------------------------------------------------
package qxmm_pkg;

    // Field widths
    localparam int IN_W   = 32;   // Q16.16 command fields
    localparam int FRC_W  = 42;   // 96 * force, signed
    localparam int CAP_W  = 30;   // capped positive force
    localparam int RHS_W  = 54;   // capped force * 1e7
    localparam int ACC_W  = 56;   // search accumulators
    localparam int Q_W    = 15;   // Q7.8 command
    localparam int A_W    = 21;   // 96 * a * 1e7
    localparam int B_W    = 34;   // 96 * 256 * b * 1e7
    localparam int MOTORS = 4;

    // Thrust curve constants, scaled by 1e7 and by the mixing factor 96
    localparam logic [A_W-1:0] A96_SIM  = A_W'(96 * 14597);
    localparam logic [A_W-1:0] A96_REAL = A_W'(96 * 10210);
    localparam logic [B_W-1:0] B96_SIM  = B_W'(64'd24576 * 64'd436930);
    localparam logic [B_W-1:0] B96_REAL = B_W'(64'd24576 * 64'd363290);

    localparam logic [CAP_W-1:0] FORCE_CAP = CAP_W'(1000000000);
    localparam logic [23:0]      RHS_SCALE = 24'd10000000;
    localparam logic [Q_W-1:0]   Q_LIMIT   = Q_W'(25600);
    localparam logic [Q_W-1:0]   Q_TOP     = Q_W'(25601);

    // Configuration register indexes
    localparam logic CFG_COEF_SET = 1'b0;
    localparam logic CFG_MIN_OUT  = 1'b1;

    typedef struct packed {
        logic signed [IN_W-1:0] collective_thrust;
        logic signed [IN_W-1:0] roll_moment;
        logic signed [IN_W-1:0] pitch_moment;
        logic signed [IN_W-1:0] yaw_moment;
    } t_cmd_in;

    typedef struct packed {
        logic [Q_W-1:0] motor_one;
        logic [Q_W-1:0] motor_two;
        logic [Q_W-1:0] motor_three;
        logic [Q_W-1:0] motor_four;
    } t_motor_out;

    // One classified request: right-hand side of the curve search per motor
    typedef struct packed {
        logic [MOTORS-1:0][RHS_W-1:0] rhs;
    } t_work;

    // Saturate search result, then apply the min-first clamp
    function automatic logic [Q_W-1:0] clamp_cmd(input logic [Q_W-1:0] q,
                                                 input logic [Q_W-1:0] min_out);
        logic [Q_W-1:0] qc;
        qc = (q > Q_TOP) ? Q_TOP : q;
        if (qc < min_out) begin
            return min_out;
        end else if (qc > Q_LIMIT) begin
            return Q_LIMIT;
        end
        return qc;
    endfunction

endpackage

>>> design/quad_x_motor_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_x_motor_mixer
// X-layout quadrotor mixer with thrust-curve inversion to Q7.8 commands.
// ----------------------------------------------------------------------------
// A request enters the two-stage front (mixing, then force clipping and
// scaling), waits in a short queue, and is solved by four lanes that find
// each motor command one bit per cycle, most significant first. The solver
// lanes load a request and run all 15 search steps before they take the
// next one. Results sit in an output register, so the next request is
// solved while a result waits. Write configuration only while idle.
// ----------------------------------------------------------------------------
module quad_x_motor_mixer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  qxmm_pkg::t_cmd_in        i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output qxmm_pkg::t_motor_out     o_out_data,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [qxmm_pkg::Q_W-1:0] i_cfg_wdata
);
    import qxmm_pkg::*;

    logic           r_coef_set;
    logic [Q_W-1:0] r_min_output;
    logic           w_f_valid, w_f_ready, w_b_valid, w_b_ready;
    t_work          w_f_work, w_b_work;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_set   <= 1'b0;
            r_min_output <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COEF_SET: r_coef_set   <= i_cfg_wdata[0];
                CFG_MIN_OUT:  r_min_output <= i_cfg_wdata;
                default:      r_coef_set   <= r_coef_set;
            endcase
        end
    end

    qxmm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_cmd   (i_in_data),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_work  (w_f_work)
    );

    qxmm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_work),
        .o_valid (w_b_valid),
        .i_ready (w_b_ready),
        .o_data  (w_b_work)
    );

    qxmm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_b_valid),
        .o_ready    (w_b_ready),
        .i_work     (w_b_work),
        .i_coef_set (r_coef_set),
        .i_min_out  (r_min_output),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

    // Motor one and four commands never exceed full scale unless the minimum forces it
    a_out_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.motor_one <= Q_LIMIT || o_out_data.motor_one == r_min_output) &&
            (o_out_data.motor_four <= Q_LIMIT || o_out_data.motor_four == r_min_output))
        else $error("motor command above full scale");

    // Motor two and three commands respect an in-range minimum
    a_out_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_min_output <= Q_LIMIT) |->
            (o_out_data.motor_two >= r_min_output &&
             o_out_data.motor_three >= r_min_output))
        else $error("motor command below minimum");

endmodule

>>> design/qxmm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_front
// Mixes a command vector into four motor forces and forms the search bound.
// ----------------------------------------------------------------------------
module qxmm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  qxmm_pkg::t_cmd_in i_cmd,
    output logic              o_valid,
    input  logic              i_ready,
    output qxmm_pkg::t_work   o_work
);
    import qxmm_pkg::*;

    logic                          r_s1_valid, r_s2_valid;
    logic signed [FRC_W-1:0]       r_frc [MOTORS];
    logic signed [FRC_W-1:0]       n_frc [MOTORS];
    t_work                         r_work, n_work;
    logic signed [FRC_W-1:0]       w_t, w_r, w_p, w_y;
    logic signed [FRC_W-1:0]       w_t24, w_r192, w_p192, w_y500;
    logic [CAP_W-1:0]              w_cap [MOTORS];
    logic                          w_en1, w_en2;

    // Stall a stage only when the queue is full and every stage from it onward holds a request
    assign w_en2   = !r_s2_valid || i_ready;
    assign w_en1   = !r_s1_valid || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_s2_valid;
    assign o_work  = r_work;

    // Mixing matrix, scaled by 96 so every weight is an integer
    always_comb begin
        w_t    = FRC_W'(i_cmd.collective_thrust);
        w_r    = FRC_W'(i_cmd.roll_moment);
        w_p    = FRC_W'(i_cmd.pitch_moment);
        w_y    = FRC_W'(i_cmd.yaw_moment);
        w_t24  = (w_t <<< 4) + (w_t <<< 3);
        w_r192 = (w_r <<< 7) + (w_r <<< 6);
        w_p192 = (w_p <<< 7) + (w_p <<< 6);
        w_y500 = (w_y <<< 9) - (w_y <<< 3) - (w_y <<< 2);
        n_frc[0] = w_t24 - w_r192 + w_p192 + w_y500;
        n_frc[1] = w_t24 + w_r192 - w_p192 + w_y500;
        n_frc[2] = w_t24 + w_r192 + w_p192 - w_y500;
        n_frc[3] = w_t24 - w_r192 - w_p192 - w_y500;
    end

    // Clip force to the usable range and scale by 1e7
    always_comb begin
        for (int k = 0; k < MOTORS; k++) begin
            if (r_frc[k] <= 0) begin
                w_cap[k] = '0;
            end else if (r_frc[k] > FRC_W'(FORCE_CAP)) begin
                w_cap[k] = FORCE_CAP;
            end else begin
                w_cap[k] = r_frc[k][CAP_W-1:0];
            end
            n_work.rhs[k] = RHS_W'(w_cap[k]) * RHS_W'(RHS_SCALE);
        end
    end

    // Advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_valid <= i_valid;
            end
            if (w_en2) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_frc <= n_frc;
        end
        if (w_en2 && r_s1_valid) begin
            r_work <= n_work;
        end
    end

endmodule

>>> design/qxmm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_fifo
// Short request queue between the front and the curve solvers.
// ----------------------------------------------------------------------------
module qxmm_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qxmm_pkg::t_work i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output qxmm_pkg::t_work o_data
);
    import qxmm_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_work              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, r_rptr;
    logic [CNT_W-1:0]   r_cnt;
    logic               w_push, w_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store request
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

>>> design/qxmm_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_lane
// Bit-serial inversion of the thrust curve, one command bit per cycle.
// ----------------------------------------------------------------------------
module qxmm_lane (
    input  logic                             i_clk,
    input  logic                             i_load,
    input  logic                             i_step,
    input  logic [qxmm_pkg::RHS_W-1:0]       i_rhs,
    input  logic [qxmm_pkg::A_W-1:0]         i_a96,
    input  logic [qxmm_pkg::B_W-1:0]         i_b96,
    output logic [qxmm_pkg::Q_W-1:0]         o_q
);
    import qxmm_pkg::*;

    // r_lhs = curve(q); r_ms = (a*q) << (k+1); r_as = a << 2k; r_bs = b << k
    logic [ACC_W-1:0] r_lhs, r_ms, r_as, r_bs;
    logic [RHS_W-1:0] r_rhs;
    logic [Q_W-1:0]   r_q, r_bit;
    logic [ACC_W-1:0] w_trial, w_ms_acc;
    logic             w_take;

    assign o_q = r_q;

    // Curve at the trial value, from shifted increments only
    always_comb begin
        w_trial  = r_lhs + r_ms + r_as + r_bs;
        w_take   = (w_trial <= ACC_W'(r_rhs));
        w_ms_acc = r_ms + (r_as << 1);
    end

    // Load bounds, then keep or drop one bit per step
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rhs <= i_rhs;
            r_lhs <= '0;
            r_ms  <= '0;
            r_as  <= ACC_W'(i_a96) << (2 * (Q_W - 1));
            r_bs  <= ACC_W'(i_b96) << (Q_W - 1);
            r_q   <= '0;
            r_bit <= Q_W'(1) << (Q_W - 1);
        end else if (i_step) begin
            if (w_take) begin
                r_lhs <= w_trial;
                r_q   <= r_q | r_bit;
                r_ms  <= w_ms_acc >> 1;
            end else begin
                r_ms  <= r_ms >> 1;
            end
            r_as  <= r_as >> 2;
            r_bs  <= r_bs >> 1;
            r_bit <= r_bit >> 1;
        end
    end

endmodule

>>> design/qxmm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_back
// Runs four curve solvers in lockstep, clamps and holds the result.
// ----------------------------------------------------------------------------
module qxmm_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  qxmm_pkg::t_work          i_work,
    input  logic                     i_coef_set,
    input  logic [qxmm_pkg::Q_W-1:0] i_min_out,
    output logic                     o_valid,
    input  logic                     i_ready,
    output qxmm_pkg::t_motor_out     o_data
);
    import qxmm_pkg::*;

    localparam int CNT_W = $clog2(Q_W);

    logic               r_busy, r_done, r_out_valid;
    logic [CNT_W-1:0]   r_cnt;
    t_motor_out         r_out, n_out;
    logic [Q_W-1:0]     w_q [MOTORS];
    logic               w_load, w_unload;
    logic [A_W-1:0]     w_a96;
    logic [B_W-1:0]     w_b96;

    assign w_unload = r_done && (!r_out_valid || i_ready);
    assign w_load   = i_valid && !r_busy && (!r_done || w_unload);
    assign o_ready  = !r_busy && (!r_done || w_unload);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;
    assign w_a96    = i_coef_set ? A96_REAL : A96_SIM;
    assign w_b96    = i_coef_set ? B96_REAL : B96_SIM;

    // Solver lanes
    for (genvar g = 0; g < MOTORS; g++) begin : g_lane
        qxmm_lane u_lane (
            .i_clk  (i_clk),
            .i_load (w_load),
            .i_step (r_busy),
            .i_rhs  (i_work.rhs[g]),
            .i_a96  (w_a96),
            .i_b96  (w_b96),
            .o_q    (w_q[g])
        );
    end

    // Clamp finished commands
    always_comb begin
        n_out.motor_one   = clamp_cmd(w_q[0], i_min_out);
        n_out.motor_two   = clamp_cmd(w_q[1], i_min_out);
        n_out.motor_three = clamp_cmd(w_q[2], i_min_out);
        n_out.motor_four  = clamp_cmd(w_q[3], i_min_out);
    end

    // Sequence the search and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            if (w_unload) begin
                r_done      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture result
    always_ff @(posedge i_clk) begin
        if (w_unload) begin
            r_out <= n_out;
        end
    end

endmodule

>>> tb/sv/qxmm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_checker
// Watches the command and motor channels of the quad X motor mixer, works
// out the four motor commands of every accepted request and compares them
// with the results in order.
// ----------------------------------------------------------------------------
module qxmm_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  qxmm_pkg::t_cmd_in        i_in_data,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  qxmm_pkg::t_motor_out     i_out_data,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [qxmm_pkg::Q_W-1:0] i_cfg_wdata,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_checked
);
    import qxmm_pkg::*;

    logic           coef_real;
    logic [Q_W-1:0] min_cmd;
    t_motor_out     motor_queue[$];

    // Largest q with 96*a*q^2 + 96*256*b*q <= 1e7 * f96, searched up to 25601
    function automatic logic [Q_W-1:0] solve_curve(input longint f96, input logic real_set);
        longint unsigned a, b, rhs, q, lhs;
        int lo, hi, mid;
        a  = real_set ? 64'd10210 : 64'd14597;
        b  = real_set ? 64'd363290 : 64'd436930;
        lo = 0;
        hi = 25601;
        if (f96 <= 0) return '0;
        if (f96 > 64'sd1000000000) f96 = 64'sd1000000000;
        rhs = f96 * 64'd10000000;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            q   = 64'(mid);
            lhs = 96 * a * q * q + 96 * 256 * b * q;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return Q_W'(lo);
    endfunction

    // Minimum check first, then the 100 percent ceiling
    function automatic logic [Q_W-1:0] limit_cmd(input logic [Q_W-1:0] q);
        if (q < min_cmd) return min_cmd;
        if (q > 15'd25600) return 15'd25600;
        return q;
    endfunction

    function automatic t_motor_out mix_motors(input t_cmd_in c);
        longint t, r, p, y;
        t_motor_out m;
        t = longint'(c.collective_thrust) * 24;
        r = longint'(c.roll_moment) * 192;
        p = longint'(c.pitch_moment) * 192;
        y = longint'(c.yaw_moment) * 500;
        m.motor_one   = limit_cmd(solve_curve(t - r + p + y, coef_real));
        m.motor_two   = limit_cmd(solve_curve(t + r - p + y, coef_real));
        m.motor_three = limit_cmd(solve_curve(t + r + p - y, coef_real));
        m.motor_four  = limit_cmd(solve_curve(t - r - p - y, coef_real));
        return m;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    assign o_pending = motor_queue.size();

    // Track config, queue predictions, compare results
    always @(posedge i_clk) begin
        t_motor_out want;
        if (!i_rst_n) begin
            coef_real = 1'b0;
            min_cmd   = '0;
            o_errors  = 0;
            o_checked = 0;
            motor_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_COEF_SET) coef_real = i_cfg_wdata[0];
                else min_cmd = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) motor_queue.push_back(mix_motors(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (motor_queue.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    want = motor_queue.pop_front();
                    o_checked++;
                    if (i_out_data.motor_one != want.motor_one)
                        report("motor_one", int'(i_out_data.motor_one),
                               int'(want.motor_one));
                    if (i_out_data.motor_two != want.motor_two)
                        report("motor_two", int'(i_out_data.motor_two),
                               int'(want.motor_two));
                    if (i_out_data.motor_three != want.motor_three)
                        report("motor_three", int'(i_out_data.motor_three),
                               int'(want.motor_three));
                    if (i_out_data.motor_four != want.motor_four)
                        report("motor_four", int'(i_out_data.motor_four),
                               int'(want.motor_four));
                end
            end
        end
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random command vectors into the quad X motor mixer
// under several coefficient and minimum settings, with random gaps and
// stalls on both channels; the checker module judges every result.
// ----------------------------------------------------------------------------
module tb_top;
    import qxmm_pkg::*;

    localparam int  RAND_ITEMS = 1400;
    localparam longint CYCLE_LIMIT = 2000000;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    t_cmd_in        in_data;
    logic           out_valid;
    logic           out_ready;
    t_motor_out     out_data;
    logic           cfg_we;
    logic           cfg_idx;
    logic [Q_W-1:0] cfg_wdata;
    int             errors, pending, checked;
    longint         cycles;
    bit             hold_off;

    quad_x_motor_mixer dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata)
    );

    qxmm_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Timeout watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAIL quad_x_motor_mixer");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: random stalls, plus one long hold-off
    initial begin
        int n;
        out_ready = 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_off) begin
                out_ready = 1'b0;
                for (n = 0; n < 300; n++) @(negedge clk);
                hold_off = 0;
            end
            n = gap_len();
            if ($urandom_range(0, 3) == 0 || n == 0) begin
                out_ready = 1'b1;
            end else begin
                out_ready = 1'b0;
                repeat (n) @(negedge clk);
                out_ready = 1'b1;
            end
        end
    end

    task automatic send_cmd(input t_cmd_in c, input bit burst);
        int n;
        n = burst ? 0 : gap_len();
        if (n > 0) begin
            in_valid = 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic idx, input logic [Q_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Wait until every result has come back, then let the pipe drain
    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_field(input int scale);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom();
        if (r == 1) return $signed(32'h8000_0000) >>> $urandom_range(0, 31);
        case (scale)
            0: return $signed(32'($urandom_range(0, 200 << 16)));
            1: return $signed(32'($urandom_range(0, 40 << 16))) - (20 << 16);
            default: return $signed(32'($urandom_range(0, 4 << 16))) - (2 << 16);
        endcase
    endfunction

    task automatic random_cmd(output t_cmd_in c);
        c.collective_thrust = pick_field(0);
        c.roll_moment       = pick_field(1);
        c.pitch_moment      = pick_field(1);
        c.yaw_moment        = pick_field(2);
    endtask

    initial begin
        t_cmd_in c;
        logic [Q_W-1:0] mins[6];
        int k, phase;
        mins = '{15'd0, 15'd25600, 15'd32767, 15'd1234, 15'd12800, 15'd1};
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_COEF_SET;
        cfg_wdata = '0;
        hold_off  = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero, extremes, each sign of each axis, saturation
        send_cmd('{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 0);
        send_cmd('{32'h7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0}, 0);
        send_cmd('{32'h8000_0000, 32'sd0, 32'sd0, 32'sd0}, 0);
        send_cmd('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 0);
        send_cmd('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 0);
        send_cmd('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0);
        send_cmd('{32'sd1, 32'sd0, 32'sd0, 32'sd0}, 0);
        send_cmd('{32'(10 << 16), 32'sd0, 32'sd0, 32'sd0}, 0);
        send_cmd('{32'(10 << 16), 32'(1 << 16), 32'sd0, 32'sd0}, 0);
        send_cmd('{32'(10 << 16), 32'sd0, 32'(1 << 16), 32'sd0}, 0);
        send_cmd('{32'(10 << 16), 32'sd0, 32'sd0, 32'(1 << 16)}, 0);
        send_cmd('{32'(10 << 16), 32'sd0, -32'sd65536, -32'sd65536}, 0);
        send_cmd('{32'(150 << 16), 32'sd0, 32'sd0, 32'sd0}, 0);
        send_cmd('{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 0);
        drain();

        // Random phases across coefficient sets and minimum clamps
        for (phase = 0; phase < 7; phase++) begin
            write_reg(CFG_COEF_SET, Q_W'(phase % 2));
            write_reg(CFG_MIN_OUT, mins[phase % 6]);
            if (phase == 2) hold_off = 1;
            for (k = 0; k < RAND_ITEMS / 7; k++) begin
                random_cmd(c);
                send_cmd(c, phase == 2 || k % 50 < 10);
            end
            drain();
        end

        $display("covered %0d requests over both thrust curves and six minimum clamps,",
                 checked);
        $display("with random gaps, stalls and one long output hold-off");
        if (errors == 0) begin
            $display("PASS quad_x_motor_mixer");
        end else begin
            $display("FAIL quad_x_motor_mixer");
        end
        $finish;
    end

endmodule
